FILE: src/dbnr_pkg.sv
// Package: shared constants, register indexes and result kind codes.
package dbnr_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_ROW_BANDS  = 3;
    localparam int DEF_COL_BANDS  = 5;

    localparam int PIXEL_W    = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int BAND_IDX_W = 3;
    localparam int KIND_W     = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0]   RESET_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0]   RESET_HEIGHT = 11'd480;
    localparam logic [PIXEL_W-1:0] DEPTH_FAR    = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CELL = 2'd0,
        KIND_ROW  = 2'd1,
        KIND_COL  = 2'd2
    } t_kind;

endpackage

FILE: src/depth_band_nearest_reduce_core.sv
// Top level: depth band nearest reduction over a raster pixel stream.
// Takes one pixel per clock with no gaps: each pixel lands in an input
// register and from there updates the position counters and the grid, row
// band and column band minimum registers. At the last pixel of a
// frame the updated minimums are copied into a snapshot and the accumulators
// restart at once, so the next frame streams in while the snapshot drains
// ROW_BANDS*COL_BANDS + ROW_BANDS + COL_BANDS results, one per clock (23 with
// the default 3 x 5 grid), grid cells first, then row bands, then column
// bands, tlast on the final one. The input stalls only when a frame ends
// while the previous frame's results are still draining, which happens for
// frames of fewer pixels than results or when the output side holds back.
module depth_band_nearest_reduce_core #(
    parameter int MAX_WIDTH  = dbnr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dbnr_pkg::DEF_MAX_HEIGHT,
    parameter int ROW_BANDS  = dbnr_pkg::DEF_ROW_BANDS,
    parameter int COL_BANDS  = dbnr_pkg::DEF_COL_BANDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dbnr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dbnr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [7:0] pixel
    input  logic [dbnr_pkg::PIXEL_W-1:0]   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [2:0] band_row, [5:3] band_col, [13:6] depth, [15:14] zero
    output logic [dbnr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] kind
    output logic [dbnr_pkg::KIND_W-1:0]    o_m_axis_tuser,
    output logic                          o_m_axis_tlast
);
    import dbnr_pkg::*;

    localparam int WB   = $clog2(MAX_WIDTH + 1);
    localparam int HB   = $clog2(MAX_HEIGHT + 1);
    localparam int CPW  = $clog2(MAX_WIDTH);
    localparam int RPW  = $clog2(MAX_HEIGHT);
    localparam int EWW  = (WB > CFG_W) ? WB : CFG_W;
    localparam int EHW  = (HB > CFG_W) ? HB : CFG_W;
    localparam int CSH  = $clog2(COL_BANDS);
    localparam int RSH  = $clog2(ROW_BANDS);
    localparam int KWC  = WB + CSH;
    localparam int KWR  = HB + RSH;
    localparam int RCPC = ((2 ** KWC) + COL_BANDS - 1) / COL_BANDS;
    localparam int RCPR = ((2 ** KWR) + ROW_BANDS - 1) / ROW_BANDS;
    localparam int CBW  = $clog2(COL_BANDS + 1);
    localparam int RBW  = $clog2(ROW_BANDS + 1);
    localparam int CIW  = (COL_BANDS > 1) ? $clog2(COL_BANDS) : 1;
    localparam int RIW  = (ROW_BANDS > 1) ? $clog2(ROW_BANDS) : 1;

    localparam logic [KWC:0] RECIP_C = (KWC + 1)'(RCPC);
    localparam logic [KWR:0] RECIP_R = (KWR + 1)'(RCPR);

    // configuration
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // input register
    logic               r_in_valid;
    logic [PIXEL_W-1:0] r_in_pixel;

    // position counters
    logic [CPW-1:0] r_col_pos, n_col_pos;
    logic [RPW-1:0] r_row_pos, n_row_pos;
    logic [CBW-1:0] r_col_band, n_col_band;
    logic [RBW-1:0] r_row_band, n_row_band;
    logic [CPW-1:0] r_col_off, n_col_off;
    logic [RPW-1:0] r_row_off, n_row_off;

    // accumulators and snapshot
    logic [PIXEL_W-1:0] r_cell [ROW_BANDS][COL_BANDS];
    logic [PIXEL_W-1:0] n_cell [ROW_BANDS][COL_BANDS];
    logic [PIXEL_W-1:0] r_rmin [ROW_BANDS];
    logic [PIXEL_W-1:0] n_rmin [ROW_BANDS];
    logic [PIXEL_W-1:0] r_cmin [COL_BANDS];
    logic [PIXEL_W-1:0] n_cmin [COL_BANDS];
    logic [PIXEL_W-1:0] r_snap_cell [ROW_BANDS][COL_BANDS];
    logic [PIXEL_W-1:0] r_snap_rmin [ROW_BANDS];
    logic [PIXEL_W-1:0] r_snap_cmin [COL_BANDS];

    // result sequencer
    logic           r_busy;
    t_kind          r_kind, n_kind;
    logic [RIW-1:0] r_seq_row, n_seq_row;
    logic [CIW-1:0] r_seq_col, n_seq_col;
    logic           seq_last;
    logic           out_hs;

    logic [EWW-1:0] width_ext;
    logic [EHW-1:0] height_ext;
    logic [WB-1:0]  w;
    logic [HB-1:0]  h;
    logic [WB+KWC:0] prod_w;
    logic [HB+KWR:0] prod_h;
    logic [WB-1:0]  band_w;
    logic [HB-1:0]  band_h;
    logic           in_col;
    logic           in_row;
    logic           col_last;
    logic           frame_last;
    logic           frame_end;
    logic           adv;
    logic [WB-1:0]  col_off_inc;
    logic [HB-1:0]  row_off_inc;
    logic [PIXEL_W-1:0] depth_sel;

    // effective dimensions and band sizes
    always_comb begin
        width_ext  = EWW'(r_width);
        height_ext = EHW'(r_height);
        if (r_width == '0) begin
            w = WB'(1);
        end else if (width_ext > EWW'(MAX_WIDTH)) begin
            w = WB'(MAX_WIDTH);
        end else begin
            w = WB'(width_ext);
        end
        if (r_height == '0) begin
            h = HB'(1);
        end else if (height_ext > EHW'(MAX_HEIGHT)) begin
            h = HB'(MAX_HEIGHT);
        end else begin
            h = HB'(height_ext);
        end
        prod_w = (WB + KWC + 1)'(w) * (WB + KWC + 1)'(RECIP_C);
        prod_h = (HB + KWR + 1)'(h) * (HB + KWR + 1)'(RECIP_R);
        band_w = prod_w[KWC +: WB];
        band_h = prod_h[KWR +: HB];
    end

    assign in_col     = (band_w != '0) && (r_col_band < CBW'(COL_BANDS));
    assign in_row     = (band_h != '0) && (r_row_band < RBW'(ROW_BANDS));
    assign col_last   = (WB'(r_col_pos) + WB'(1)) >= w;
    assign frame_last = (HB'(r_row_pos) + HB'(1)) >= h;
    assign frame_end  = col_last && frame_last;
    assign col_off_inc = WB'(r_col_off) + WB'(1);
    assign row_off_inc = HB'(r_row_off) + HB'(1);

    assign out_hs = r_busy && i_m_axis_tready;
    assign seq_last = (r_kind == KIND_COL) && (r_seq_col == CIW'(COL_BANDS - 1));
    assign adv = r_in_valid && (!frame_end || !r_busy || (out_hs && seq_last));
    assign o_s_axis_tready = !r_in_valid || adv;

    // position counter update
    always_comb begin
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        n_col_band = r_col_band;
        n_row_band = r_row_band;
        n_col_off  = r_col_off;
        n_row_off  = r_row_off;
        if (!col_last) begin
            n_col_pos = r_col_pos + CPW'(1);
            if (in_col) begin
                if (col_off_inc >= band_w) begin
                    n_col_off  = '0;
                    n_col_band = r_col_band + CBW'(1);
                end else begin
                    n_col_off = CPW'(col_off_inc);
                end
            end
        end else begin
            n_col_pos  = '0;
            n_col_band = '0;
            n_col_off  = '0;
            if (!frame_last) begin
                n_row_pos = r_row_pos + RPW'(1);
                if (in_row) begin
                    if (row_off_inc >= band_h) begin
                        n_row_off  = '0;
                        n_row_band = r_row_band + RBW'(1);
                    end else begin
                        n_row_off = RPW'(row_off_inc);
                    end
                end
            end else begin
                n_row_pos  = '0;
                n_row_band = '0;
                n_row_off  = '0;
            end
        end
    end

    // running minimums with the current pixel
    always_comb begin
        for (int i = 0; i < ROW_BANDS; i++) begin
            for (int j = 0; j < COL_BANDS; j++) begin
                n_cell[i][j] = r_cell[i][j];
                if (in_row && in_col && (r_row_band == RBW'(i)) &&
                    (r_col_band == CBW'(j)) && (r_in_pixel < r_cell[i][j])) begin
                    n_cell[i][j] = r_in_pixel;
                end
            end
        end
        for (int i = 0; i < ROW_BANDS; i++) begin
            n_rmin[i] = r_rmin[i];
            if ((r_in_pixel != '0) && in_row && (r_row_band == RBW'(i)) &&
                (r_in_pixel < r_rmin[i])) begin
                n_rmin[i] = r_in_pixel;
            end
        end
        for (int j = 0; j < COL_BANDS; j++) begin
            n_cmin[j] = r_cmin[j];
            if ((r_in_pixel != '0) && in_col && (r_col_band == CBW'(j)) &&
                (r_in_pixel < r_cmin[j])) begin
                n_cmin[j] = r_in_pixel;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready) begin
            r_in_pixel <= i_s_axis_tdata;
        end
    end

    // accumulate, restart at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_col_band <= '0;
            r_row_band <= '0;
            r_col_off  <= '0;
            r_row_off  <= '0;
            for (int i = 0; i < ROW_BANDS; i++) begin
                for (int j = 0; j < COL_BANDS; j++) begin
                    r_cell[i][j] <= DEPTH_FAR;
                end
                r_rmin[i] <= DEPTH_FAR;
            end
            for (int j = 0; j < COL_BANDS; j++) begin
                r_cmin[j] <= DEPTH_FAR;
            end
        end else if (adv) begin
            r_col_pos  <= n_col_pos;
            r_row_pos  <= n_row_pos;
            r_col_band <= n_col_band;
            r_row_band <= n_row_band;
            r_col_off  <= n_col_off;
            r_row_off  <= n_row_off;
            for (int i = 0; i < ROW_BANDS; i++) begin
                for (int j = 0; j < COL_BANDS; j++) begin
                    r_cell[i][j] <= frame_end ? DEPTH_FAR : n_cell[i][j];
                end
                r_rmin[i] <= frame_end ? DEPTH_FAR : n_rmin[i];
            end
            for (int j = 0; j < COL_BANDS; j++) begin
                r_cmin[j] <= frame_end ? DEPTH_FAR : n_cmin[j];
            end
        end
    end

    // snapshot of the finished frame
    always_ff @(posedge i_clk) begin
        if (adv && frame_end) begin
            for (int i = 0; i < ROW_BANDS; i++) begin
                for (int j = 0; j < COL_BANDS; j++) begin
                    r_snap_cell[i][j] <= n_cell[i][j];
                end
                r_snap_rmin[i] <= n_rmin[i];
            end
            for (int j = 0; j < COL_BANDS; j++) begin
                r_snap_cmin[j] <= n_cmin[j];
            end
        end
    end

    // result sequencer next state
    always_comb begin
        n_kind    = r_kind;
        n_seq_row = r_seq_row;
        n_seq_col = r_seq_col;
        if (out_hs) begin
            case (r_kind)
                KIND_CELL: begin
                    if (r_seq_col == CIW'(COL_BANDS - 1)) begin
                        n_seq_col = '0;
                        if (r_seq_row == RIW'(ROW_BANDS - 1)) begin
                            n_seq_row = '0;
                            n_kind    = KIND_ROW;
                        end else begin
                            n_seq_row = r_seq_row + RIW'(1);
                        end
                    end else begin
                        n_seq_col = r_seq_col + CIW'(1);
                    end
                end
                KIND_ROW: begin
                    if (r_seq_row == RIW'(ROW_BANDS - 1)) begin
                        n_seq_row = '0;
                        n_kind    = KIND_COL;
                    end else begin
                        n_seq_row = r_seq_row + RIW'(1);
                    end
                end
                KIND_COL: begin
                    n_seq_col = r_seq_col + CIW'(1);
                end
                default: begin
                    n_kind = KIND_CELL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_kind    <= KIND_CELL;
            r_seq_row <= '0;
            r_seq_col <= '0;
        end else if (adv && frame_end) begin
            r_busy    <= 1'b1;
            r_kind    <= KIND_CELL;
            r_seq_row <= '0;
            r_seq_col <= '0;
        end else if (out_hs && seq_last) begin
            r_busy    <= 1'b0;
            r_kind    <= KIND_CELL;
            r_seq_row <= '0;
            r_seq_col <= '0;
        end else begin
            r_kind    <= n_kind;
            r_seq_row <= n_seq_row;
            r_seq_col <= n_seq_col;
        end
    end

    // result outputs
    always_comb begin
        case (r_kind)
            KIND_CELL: depth_sel = r_snap_cell[r_seq_row][r_seq_col];
            KIND_ROW:  depth_sel = r_snap_rmin[r_seq_row];
            KIND_COL:  depth_sel = r_snap_cmin[r_seq_col];
            default:   depth_sel = DEPTH_FAR;
        endcase
        o_m_axis_tvalid = r_busy;
        o_m_axis_tuser  = r_kind;
        o_m_axis_tlast  = seq_last;
        o_m_axis_tdata  = {2'b00, depth_sel,
                           (r_kind == KIND_ROW) ? BAND_IDX_W'(0) : BAND_IDX_W'(r_seq_col),
                           (r_kind == KIND_COL) ? BAND_IDX_W'(0) : BAND_IDX_W'(r_seq_row)};
    end

endmodule

FILE: src/dbnr_checker.sv
// Checker: result stream properties seen at the top level ports, and its bind.
module dbnr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [dbnr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [dbnr_pkg::KIND_W-1:0]     o_m_axis_tuser,
    input logic                           o_m_axis_tlast
);
    import dbnr_pkg::*;

    logic out_hs;
    assign out_hs = o_m_axis_tvalid && i_m_axis_tready;

    // hold a stalled request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("result changed while stalled");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tuser == KIND_COL))
        else $error("tlast on a result that is not a column band");

    a_col_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_hs && (o_m_axis_tuser == KIND_COL) && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid && (o_m_axis_tuser == KIND_COL)))
        else $error("column band run broken before tlast");

    a_row_no_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_ROW)) |-> (o_m_axis_tdata[5:3] == 3'd0))
        else $error("row band result carries a column index");

endmodule

bind depth_band_nearest_reduce_core dbnr_checker u_dbnr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
